[src/charge_termination_controller_defines.svh]
// ----------------------------------------------------------------------------
// charge termination controller assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef CHARGE_TERMINATION_CONTROLLER_DEFINES_SVH
`define CHARGE_TERMINATION_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define CTC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/ctc_pkg.sv]
// ----------------------------------------------------------------------------
// ctc_pkg
// types, codes and helpers of the charge termination controller
// ----------------------------------------------------------------------------
package ctc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    CAUSE_NONE      = 3'd0,
    CAUSE_DELTA_V   = 3'd1,
    CAUSE_LOW_CURR  = 3'd2,
    CAUSE_DUTY_EXH  = 3'd3,
    CAUSE_DUTY_ZERO = 3'd4
  } cause_t;

  typedef enum logic [1:0] {
    REG_DV_MODE = 2'd0,
    REG_VLIMIT  = 2'd1,
    REG_IR      = 2'd2
  } reg_index_t;

  localparam logic [13:0] VLIMIT_RESET  = 14'd7000;
  localparam logic [9:0]  MILLI         = 10'd1000;
  localparam logic [13:0] DROP_MV       = 14'd22;
  localparam logic [11:0] MIN_CURR_MA   = 12'd80;
  localparam logic [6:0]  SETTLE_ON_DROP = 7'd50;
  localparam logic [2:0]  COUNT_LIMIT   = 3'd5;
  localparam logic [2:0]  DROP_SAT      = 3'd7;
  localparam logic [31:0] RECIP5        = 32'd52429;

  typedef struct packed {
    logic        active;
    logic [3:0]  duty_level;
    logic [6:0]  settle_count;
    logic [13:0] peak_mv;
    logic [2:0]  rise_count;
    logic [2:0]  drop_count;
  } ctc_state_t;

  typedef struct packed {
    logic        dv_mode;
    logic [13:0] vlimit_mv;
    logic [10:0] ir_milliohm;
  } ctc_cfg_t;

  typedef struct packed {
    logic [3:0] duty_out;
    logic       is_charging;
    logic       finished;
    cause_t     end_cause;
  } ctc_result_t;

  // floor(x / 5) by reciprocal, exact for 14-bit x
  function automatic logic [13:0] div5(input logic [13:0] x);
    logic [31:0] p;
    p = {18'd0, x} * RECIP5;
    return p[31:18];
  endfunction

endpackage

[src/ctc_update.sv]
// ----------------------------------------------------------------------------
// ctc_update
// next-state and result logic for one item
// ----------------------------------------------------------------------------
module ctc_update import ctc_pkg::*; #(
  parameter logic [3:0] DUTY_CAP     = 4'd11,
  parameter logic [6:0] SETTLE_TICKS = 7'd100
) (
  input  ctc_cfg_t    cfg,
  input  ctc_state_t  cur,
  input  logic [1:0]  action,
  input  logic [13:0] voltage_mv,
  input  logic [11:0] current_ma,
  input  logic [3:0]  start_duty,
  output ctc_state_t  nxt,
  output ctc_result_t res
);

  logic [24:0] lhs;
  logic [24:0] rhs;
  logic        over_limit;

  assign lhs = {11'd0, voltage_mv} * {15'd0, MILLI};
  assign rhs = ({11'd0, cfg.vlimit_mv} * {15'd0, MILLI})
             + ({14'd0, cfg.ir_milliohm} * {13'd0, current_ma});
  assign over_limit = lhs > rhs;

  always_comb begin
    logic        done;
    cause_t      cause;
    logic [2:0]  rise;
    logic [3:0]  duty_dec;
    nxt      = cur;
    done     = 1'b0;
    cause    = CAUSE_NONE;
    rise     = 3'd0;
    duty_dec = cur.duty_level - 4'd1;
    case (action_t'(action))
      ACT_TICK: begin
        if (cur.active) begin
          if (cur.duty_level == 4'd0) begin
            done  = 1'b1;
            cause = CAUSE_DUTY_ZERO;
          end else if (cur.settle_count < SETTLE_TICKS) begin
            nxt.settle_count = cur.settle_count + 7'd1;
          end else if (cfg.dv_mode) begin
            if (voltage_mv > cur.peak_mv) begin
              rise = cur.rise_count + 3'd1;
              if (rise > COUNT_LIMIT) begin
                nxt.peak_mv = cur.peak_mv + div5(voltage_mv - cur.peak_mv);
                rise = 3'd0;
              end
              nxt.rise_count = rise;
              nxt.drop_count = 3'd0;
            end
            if (nxt.peak_mv > voltage_mv && (nxt.peak_mv - voltage_mv) > DROP_MV) begin
              if (nxt.drop_count < DROP_SAT) begin
                nxt.drop_count = nxt.drop_count + 3'd1;
              end
              nxt.settle_count = SETTLE_ON_DROP;
            end
            if (nxt.drop_count > COUNT_LIMIT) begin
              done  = 1'b1;
              cause = CAUSE_DELTA_V;
            end
          end else begin
            if (current_ma < MIN_CURR_MA) begin
              done  = 1'b1;
              cause = CAUSE_LOW_CURR;
            end else if (over_limit) begin
              nxt.duty_level   = duty_dec;
              nxt.settle_count = 7'd0;
              if (duty_dec == 4'd0) begin
                done  = 1'b1;
                cause = CAUSE_DUTY_EXH;
              end
            end
          end
        end
      end
      ACT_START: begin
        nxt.active       = 1'b1;
        nxt.duty_level   = (start_duty > DUTY_CAP) ? DUTY_CAP : start_duty;
        nxt.settle_count = 7'd0;
        nxt.peak_mv      = 14'd0;
        nxt.rise_count   = 3'd0;
        nxt.drop_count   = 3'd0;
      end
      ACT_STOP: begin
        nxt.active     = 1'b0;
        nxt.duty_level = 4'd0;
      end
      default: begin
        nxt = cur;
      end
    endcase
    if (done) begin
      nxt.active     = 1'b0;
      nxt.duty_level = 4'd0;
    end
    res.duty_out    = nxt.duty_level;
    res.is_charging = nxt.active;
    res.finished    = done;
    res.end_cause   = cause;
  end

endmodule

[src/charge_termination_controller.sv]
// ----------------------------------------------------------------------------
// charge_termination_controller
// battery charge termination by negative delta V or low current
// ----------------------------------------------------------------------------
// Accepts one item per clock while res_stall is not holding back a valid
// result, and returns one result per item. An item is captured in the input
// register, and when it advances the charge state and the result register
// are updated together and the result becomes valid. The state update loop
// (settle, peak and drop tracking, and the compensated voltage limit compare
// with its single resistance-by-current multiply) sets this rate. Configuration
// writes take effect at once and should only be made while no item is in flight.
`include "charge_termination_controller_defines.svh"

module charge_termination_controller import ctc_pkg::*; #(
  parameter logic [3:0] DUTY_CAP     = 4'd11,
  parameter logic [6:0] SETTLE_TICKS = 7'd100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [13:0] wr_data,
  input  logic        meas_valid,
  output logic        meas_stall,
  input  logic [1:0]  action,
  input  logic [13:0] voltage_mv,
  input  logic [11:0] current_ma,
  input  logic [3:0]  start_duty,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [3:0]  duty_out,
  output logic        is_charging,
  output logic        finished,
  output logic [2:0]  end_cause
);

  ctc_cfg_t    cfg;
  ctc_state_t  state;
  ctc_state_t  state_next;
  ctc_result_t result;
  ctc_result_t result_next;

  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [13:0] s1_voltage;
  logic [11:0] s1_current;
  logic [3:0]  s1_duty;
  logic        advance;

  assign advance    = !res_valid || !res_stall;
  assign meas_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dv_mode     <= 1'b0;
      cfg.vlimit_mv   <= VLIMIT_RESET;
      cfg.ir_milliohm <= 11'd0;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_DV_MODE: cfg.dv_mode     <= wr_data[0];
        REG_VLIMIT:  cfg.vlimit_mv   <= wr_data;
        REG_IR:      cfg.ir_milliohm <= wr_data[10:0];
        default:     cfg             <= cfg;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!meas_stall) begin
      s1_valid <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_valid && !meas_stall) begin
      s1_action  <= action;
      s1_voltage <= voltage_mv;
      s1_current <= current_ma;
      s1_duty    <= start_duty;
    end
  end

  ctc_update #(
    .DUTY_CAP     (DUTY_CAP),
    .SETTLE_TICKS (SETTLE_TICKS)
  ) u_update (
    .cfg        (cfg),
    .cur        (state),
    .action     (s1_action),
    .voltage_mv (s1_voltage),
    .current_ma (s1_current),
    .start_duty (s1_duty),
    .nxt        (state_next),
    .res        (result_next)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      state     <= '0;
    end else if (advance) begin
      res_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  assign duty_out    = result.duty_out;
  assign is_charging = result.is_charging;
  assign finished    = result.finished;
  assign end_cause   = result.end_cause;

  `CTC_ASSERT_NOW(a_idle_duty_zero, !state.active, state.duty_level == 4'd0)
  `CTC_ASSERT_NOW(a_finish_clears, res_valid && finished,
                  duty_out == 4'd0 && !is_charging && end_cause != CAUSE_NONE)
  `CTC_ASSERT_NOW(a_no_cause_unfinished, res_valid && !finished, end_cause == CAUSE_NONE)
  `CTC_ASSERT_NEXT(a_stage_moves, s1_valid && advance, res_valid)

endmodule
